### hw/rtl/tgs_pkg.sv
// Shared types, constants and table builders for the tempo-synced gain shaper.
// Used by every module under hw/rtl; depends on nothing else.
package tgs_pkg;

  // Field widths fixed by the interface
  localparam int FRAME_W    = 48;
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int PHASE_W    = 32;
  localparam int MIX_W      = 16;
  localparam int COUNT_W    = 3;
  localparam int POINT_W    = 49;
  localparam int PX_W       = 17;
  localparam int PY_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 49;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_POINTS       = 5;
  localparam int DEF_CURVE_TABLE_SIZE = 256;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Quotient bits of the segment position
  localparam int DIV_STEPS = 16;

  // Arithmetic constants
  localparam logic [GAIN_W-1:0] UNITY_Q15       = 16'h8000;
  localparam logic [MIX_W-1:0]  MIX_FLOOR       = 16'd33;
  localparam logic [14:0]       CURVE_POS_SCALE = 15'd29491;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_CNT  = 3'd2;
  localparam int                   REG_POINT_BASE = 3;

  // Register reset values
  localparam logic [PHASE_W-1:0] RST_PHASE_STEP = 32'd194783;
  localparam logic [MIX_W-1:0]   RST_MIX_AMOUNT = 16'd32768;
  localparam logic [COUNT_W-1:0] RST_POINT_CNT  = 3'd3;
  localparam logic [POINT_W-1:0] RST_POINT_ONE  = 49'd140741783339008;
  localparam logic [POINT_W-1:0] RST_POINT_TWO  = 49'd4295032832;

  typedef struct packed {
    logic [FRAME_W-1:0]         frame_number;
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [GAIN_W-1:0]          effective_gain;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [MIX_W-1:0]   mix_amount;
    logic [COUNT_W-1:0] point_count;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_UNITY,
    KIND_FLAT,
    KIND_CURVE
  } kind_t;

  // Classified frame handed from front to back
  typedef struct packed {
    kind_t                      kind;
    logic [GAIN_W-1:0]          flat_g;
    logic [PX_W-1:0]            num;
    logic [PX_W-1:0]            den;
    logic [PY_W-1:0]            y0;
    logic [PY_W-1:0]            dy;
    logic                       dy_neg;
    logic signed [15:0]         curve;
    logic [SAMPLE_W-1:0]        left;
    logic [SAMPLE_W-1:0]        right;
  } seg_item_t;

  // Bitwise integer square root, elaboration only
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bitv;
    res  = '0;
    rem  = v;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // log2 of a Q2.30 mantissa by repeated squaring, Q0.16 result
  function automatic logic [15:0] log_entry(logic [63:0] x0);
    logic [63:0] x;
    logic [15:0] y;
    x = x0;
    y = '0;
    for (int i = 1; i <= 16; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        y[16-i] = 1'b1;
      end
    end
    return y;
  endfunction

  // 2^(-fr/65536) from a product of square-root powers, Q1.16 result
  function automatic logic [16:0] exp_entry(logic [15:0] fr);
    logic [63:0] roots [17];
    logic [63:0] acc;
    roots[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) roots[i] = isqrt64(roots[i-1] << 30);
    acc = 64'd1 << 30;
    for (int i = 1; i <= 16; i++) begin
      if (fr[16-i]) acc = (acc * roots[i]) >> 30;
    end
    return 17'(acc >> 14);
  endfunction

endpackage

### hw/rtl/tempo_synced_gain_shaper.sv
// Top level of the tempo-synced gain shaper: configuration registers,
// front end, queue and back end. Depends on tgs_pkg, tgs_front, tgs_queue, tgs_back.
//
//   port group  direction  handshake             beat
//   in_*        in         in_valid / in_ready   frame number and two samples
//   out_*       out        out_valid / out_ready two scaled samples and gain
//   cfg_*       in         cfg_valid / cfg_ready register index and data
//
// One frame per cycle sustained while out_ready holds high. An input beat passes
// through two front stages, the queue, the divider input stage, the 16-step divider,
// the log, power, exponential, interpolation and mix stages and the output register.
// Synchronous active-low reset restores the default curve and empties the pipe.
// An output stall freezes the back end; the four-entry queue lets the front
// keep accepting until it fills.
module tempo_synced_gain_shaper #(
  parameter int MAX_POINTS       = tgs_pkg::DEF_MAX_POINTS,
  parameter int CURVE_TABLE_SIZE = tgs_pkg::DEF_CURVE_TABLE_SIZE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tgs_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tgs_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgs_pkg::*;

  cfg_t               cfg_r;
  logic [POINT_W-1:0] point_r [MAX_POINTS];
  logic               q_push_valid;
  logic               q_push_ready;
  seg_item_t          q_push_item;
  logic               q_pop_valid;
  logic               q_pop_ready;
  seg_item_t          q_pop_item;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step  <= RST_PHASE_STEP;
      cfg_r.mix_amount  <= RST_MIX_AMOUNT;
      cfg_r.point_count <= RST_POINT_CNT;
      for (int j = 0; j < MAX_POINTS; j++) begin
        if (j == 1)      point_r[j] <= RST_POINT_ONE;
        else if (j == 2) point_r[j] <= RST_POINT_TWO;
        else             point_r[j] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PHASE_STEP: cfg_r.phase_step  <= cfg_data[PHASE_W-1:0];
        REG_MIX_AMOUNT: cfg_r.mix_amount  <= cfg_data[MIX_W-1:0];
        REG_POINT_CNT:  cfg_r.point_count <= cfg_data[COUNT_W-1:0];
        default: begin
          for (int j = 0; j < MAX_POINTS; j++) begin
            if (32'(cfg_index) == 32'(REG_POINT_BASE + j)) point_r[j] <= cfg_data;
          end
        end
      endcase
    end
  end

  tgs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cfg      (cfg_r),
    .points   (point_r),
    .q_valid  (q_push_valid),
    .q_ready  (q_push_ready),
    .q_item   (q_push_item)
  );

  tgs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  tgs_back #(.CURVE_TABLE_SIZE(CURVE_TABLE_SIZE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_pop_valid),
    .q_ready    (q_pop_ready),
    .q_item     (q_pop_item),
    .mix_amount (cfg_r.mix_amount),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

### hw/rtl/tgs_front.sv
// Front end: beat phase multiply and breakpoint segment classification.
// Depends on tgs_pkg; feeds tgs_queue.
module tgs_front #(
  parameter int MAX_POINTS = tgs_pkg::DEF_MAX_POINTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  tgs_pkg::in_item_t        in_item,
  input  tgs_pkg::cfg_t            cfg,
  input  logic [tgs_pkg::POINT_W-1:0] points [MAX_POINTS],
  output logic                     q_valid,
  input  logic                     q_ready,
  output tgs_pkg::seg_item_t       q_item
);
  import tgs_pkg::*;

  logic               en;
  logic               f1_v_r;
  in_item_t           f1_item_r;
  logic [15:0]        p_r;
  logic [PHASE_W-1:0] frac;
  logic               f2_v_r;
  seg_item_t          seg_r;
  seg_item_t          seg_nxt;
  logic [COUNT_W-1:0] cnt;
  logic [PX_W-1:0]    p17;
  logic [PX_W-1:0]    xlast;
  logic [PY_W-1:0]    ylast;
  logic               found;
  logic [PX_W-1:0]    pt_x [MAX_POINTS];
  logic [PY_W-1:0]    pt_y [MAX_POINTS];
  logic [15:0]        pt_c [MAX_POINTS];

  // Unpack breakpoints
  always_comb begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      pt_x[j] = points[j][16:0];
      pt_y[j] = points[j][32:17];
      pt_c[j] = points[j][48:33];
    end
  end

  // Advance both stages together unless the queue holds us back
  assign en       = !f2_v_r || q_ready;
  assign in_ready = en;

  // Low 32 bits of frame times step; the phase is its top half
  assign frac = in_item.frame_number[PHASE_W-1:0] * cfg.phase_step;

  assign cnt = (cfg.point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS)
                                                       : cfg.point_count;
  assign p17 = {1'b0, p_r};

  // Classify the phase against the curve
  always_comb begin
    seg_nxt        = '0;
    seg_nxt.left   = f1_item_r.in_left;
    seg_nxt.right  = f1_item_r.in_right;
    seg_nxt.kind   = KIND_FLAT;
    seg_nxt.flat_g = UNITY_Q15;
    found          = 1'b0;
    xlast          = pt_x[0];
    ylast          = pt_y[0];
    for (int j = 1; j < MAX_POINTS; j++) begin
      if (cnt == COUNT_W'(j + 1)) begin
        xlast = pt_x[j];
        ylast = pt_y[j];
      end
    end
    if (cfg.mix_amount < MIX_FLOOR || cfg.point_count == '0) begin
      seg_nxt.kind = KIND_UNITY;
    end else if (p17 <= pt_x[0]) begin
      seg_nxt.flat_g = pt_y[0];
    end else if (p17 >= xlast) begin
      seg_nxt.flat_g = ylast;
    end else begin
      for (int i = 0; i < MAX_POINTS - 1; i++) begin
        if (!found && cnt > COUNT_W'(i + 1) && p17 >= pt_x[i] && p17 < pt_x[i+1]) begin
          found         = 1'b1;
          seg_nxt.kind  = KIND_CURVE;
          seg_nxt.num   = p17 - pt_x[i];
          seg_nxt.den   = pt_x[i+1] - pt_x[i];
          seg_nxt.y0    = pt_y[i];
          seg_nxt.curve = pt_c[i];
          if (pt_y[i+1] >= pt_y[i]) begin
            seg_nxt.dy     = pt_y[i+1] - pt_y[i];
            seg_nxt.dy_neg = 1'b0;
          end else begin
            seg_nxt.dy     = pt_y[i] - pt_y[i+1];
            seg_nxt.dy_neg = 1'b1;
          end
        end
      end
    end
  end

  // Hold stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      f1_item_r <= in_item;
      p_r       <= frac[31:16];
      seg_r     <= seg_nxt;
    end
  end

  assign q_valid = f2_v_r;
  assign q_item  = seg_r;

endmodule

### hw/rtl/tgs_queue.sv
// Short queue of classified frames between front and back.
// Depends on tgs_pkg for the entry type and depth.
module tgs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  tgs_pkg::seg_item_t  push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tgs_pkg::seg_item_t  pop_item
);
  import tgs_pkg::*;

  seg_item_t           slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                push;
  logic                pop;

  assign push_ready = (count_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

### hw/rtl/tgs_back.sv
// Back end: segment division, curve power, interpolation, mix and scaling.
// Depends on tgs_pkg; drains tgs_queue and drives the result channel.
module tgs_back #(
  parameter int CURVE_TABLE_SIZE = tgs_pkg::DEF_CURVE_TABLE_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  tgs_pkg::seg_item_t      q_item,
  input  logic [tgs_pkg::MIX_W-1:0] mix_amount,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tgs_pkg::out_item_t      out_item
);
  import tgs_pkg::*;

  localparam int IW = $clog2(CURVE_TABLE_SIZE);

  typedef struct packed {
    kind_t               kind;
    logic [GAIN_W-1:0]   flat_g;
    logic [PY_W-1:0]     y0;
    logic [PY_W-1:0]     dy;
    logic                dy_neg;
    logic                linear;
    logic [17:0]         expo;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } ctx_t;

  // Curve tables
  logic [15:0] log_rom [CURVE_TABLE_SIZE];
  logic [16:0] exp_rom [CURVE_TABLE_SIZE];

  for (genvar k = 0; k < CURVE_TABLE_SIZE; k++) begin : g_rom
    localparam logic [63:0] LX0 = (64'd1 << 30) + ((64'(k) << 30) / CURVE_TABLE_SIZE);
    localparam logic [63:0] LFR = (64'(k) << 16) / CURVE_TABLE_SIZE;
    localparam logic [15:0] LV  = log_entry(LX0);
    localparam logic [16:0] EV  = exp_entry(LFR[15:0]);
    assign log_rom[k] = LV;
    assign exp_rom[k] = EV;
  end

  logic en;
  assign en      = !out_valid || out_ready;
  assign q_ready = en;

  // Exponent from the segment curve
  logic [29:0] cpos_prod;
  logic [15:0] cneg_mag;
  ctx_t        ctx_in;

  assign cpos_prod = q_item.curve[14:0] * CURVE_POS_SCALE;
  assign cneg_mag  = 16'(-q_item.curve);

  always_comb begin
    ctx_in        = '0;
    ctx_in.kind   = q_item.kind;
    ctx_in.flat_g = q_item.flat_g;
    ctx_in.y0     = q_item.y0;
    ctx_in.dy     = q_item.dy;
    ctx_in.dy_neg = q_item.dy_neg;
    ctx_in.linear = (q_item.curve == '0);
    ctx_in.left   = q_item.left;
    ctx_in.right  = q_item.right;
    if (q_item.curve[15]) ctx_in.expo = 18'd32768 + {cneg_mag, 2'b00};
    else                  ctx_in.expo = 18'd32768 - 18'(cpos_prod[29:15]);
  end

  // Divider stages, one quotient bit each
  logic              div_v_r   [DIV_STEPS+1];
  logic [PX_W-1:0]   div_rem_r [DIV_STEPS+1];
  logic [PX_W-1:0]   div_den_r [DIV_STEPS+1];
  logic [15:0]       div_quo_r [DIV_STEPS+1];
  ctx_t              div_ctx_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) div_v_r[0] <= 1'b0;
    else if (en) div_v_r[0] <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_rem_r[0] <= q_item.num;
      div_den_r[0] <= q_item.den;
      div_quo_r[0] <= '0;
      div_ctx_r[0] <= ctx_in;
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [PX_W:0] shl;
    logic          take;

    assign shl  = {div_rem_r[s], 1'b0};
    assign take = (shl >= {1'b0, div_den_r[s]});

    always_ff @(posedge clk) begin
      if (!rst_n) div_v_r[s+1] <= 1'b0;
      else if (en) div_v_r[s+1] <= div_v_r[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_rem_r[s+1] <= take ? PX_W'(shl - {1'b0, div_den_r[s]}) : shl[PX_W-1:0];
        div_den_r[s+1] <= div_den_r[s];
        div_quo_r[s+1] <= {div_quo_r[s][14:0], take};
        div_ctx_r[s+1] <= div_ctx_r[s];
      end
    end
  end

  // Stage 1: leading one and log lookup
  logic [15:0] t_div;
  logic [3:0]  lead;
  logic [15:0] mant;
  logic [31:0] lidx_prod;
  logic [IW-1:0] lidx;
  logic [20:0] lg_nxt;

  assign t_div = div_quo_r[DIV_STEPS];

  always_comb begin
    lead = '0;
    for (int b = 1; b < 16; b++) begin
      if (t_div[b]) lead = 4'(b);
    end
  end

  assign mant      = t_div << (4'd15 - lead);
  assign lidx_prod = 32'(mant[14:0]) * 32'(CURVE_TABLE_SIZE);
  assign lidx      = IW'(lidx_prod >> 15);
  assign lg_nxt    = {5'd16 - {1'b0, lead}, 16'h0000} - {5'b0, log_rom[lidx]};

  logic        s1_v_r;
  logic [15:0] s1_t_r;
  logic [20:0] s1_lg_r;
  ctx_t        s1_ctx_r;

  // Stage 2: scale the log by the exponent
  logic [38:0] q_prod;
  logic        s2_v_r;
  logic [15:0] s2_t_r;
  logic [23:0] s2_q_r;
  ctx_t        s2_ctx_r;

  assign q_prod = s1_lg_r * s1_ctx_r.expo;

  // Stage 3: exponential lookup and shift
  logic [31:0]   eidx_prod;
  logic [IW-1:0] eidx;
  logic [16:0]   pw;
  logic [16:0]   r_nxt;

  assign eidx_prod = 32'(s2_q_r[15:0]) * 32'(CURVE_TABLE_SIZE);
  assign eidx      = IW'(eidx_prod >> 16);
  assign pw        = (s2_q_r[23:16] >= 8'd32) ? '0 : (exp_rom[eidx] >> s2_q_r[20:16]);

  always_comb begin
    if (s2_t_r == '0)             r_nxt = '0;
    else if (s2_ctx_r.linear)     r_nxt = {1'b0, s2_t_r};
    else                          r_nxt = pw;
  end

  logic        s3_v_r;
  logic [16:0] s3_r_r;
  ctx_t        s3_ctx_r;

  // Stage 4: interpolate between the segment ends
  logic [32:0]       ip_prod;
  logic [GAIN_W-1:0] g_nxt;

  assign ip_prod = s3_r_r * s3_ctx_r.dy;

  always_comb begin
    case (s3_ctx_r.kind)
      KIND_CURVE: begin
        if (s3_ctx_r.dy_neg) g_nxt = s3_ctx_r.y0 - ip_prod[31:16];
        else                 g_nxt = s3_ctx_r.y0 + ip_prod[31:16];
      end
      KIND_FLAT:  g_nxt = s3_ctx_r.flat_g;
      default:    g_nxt = UNITY_Q15;
    endcase
  end

  logic              s4_v_r;
  logic [GAIN_W-1:0] s4_g_r;
  ctx_t              s4_ctx_r;

  // Stage 5: mix with unity and clamp
  logic [30:0]       up_prod;
  logic [15:0]       dn_diff;
  logic [31:0]       dn_prod;
  logic [16:0]       up_sum;
  logic [GAIN_W-1:0] eff_nxt;

  assign up_prod = s4_g_r[14:0] * mix_amount;
  assign dn_diff = UNITY_Q15 - s4_g_r;
  assign dn_prod = dn_diff * mix_amount;
  assign up_sum  = 17'(UNITY_Q15) + {1'b0, up_prod[30:15]};

  always_comb begin
    if (s4_ctx_r.kind == KIND_UNITY) begin
      eff_nxt = UNITY_Q15;
    end else if (s4_g_r >= UNITY_Q15) begin
      eff_nxt = up_sum[16] ? 16'hFFFF : up_sum[15:0];
    end else if (dn_prod[31:15] >= 17'd32768) begin
      eff_nxt = '0;
    end else begin
      eff_nxt = 16'(17'd32768 - dn_prod[31:15]);
    end
  end

  logic              s5_v_r;
  logic [GAIN_W-1:0] s5_eff_r;
  ctx_t              s5_ctx_r;

  // Sign-magnitude scaling with saturation
  function automatic logic [SAMPLE_W-1:0] scale_sample(logic [SAMPLE_W-1:0] raw,
                                                      logic [GAIN_W-1:0] eff);
    logic                       neg;
    logic [SAMPLE_W-1:0]        mag;
    logic [SAMPLE_W+GAIN_W-1:0] prod;
    logic [SAMPLE_W:0]          qv;
    logic [SAMPLE_W-1:0]        res;
    neg  = raw[SAMPLE_W-1];
    mag  = neg ? (~raw + 1'b1) : raw;
    prod = (SAMPLE_W+GAIN_W)'(mag) * (SAMPLE_W+GAIN_W)'(eff);
    qv   = prod[SAMPLE_W+GAIN_W-1:15];
    if (!neg) begin
      if (qv > (SAMPLE_W+1)'({1'b0, {(SAMPLE_W-1){1'b1}}}))
        res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      else
        res = qv[SAMPLE_W-1:0];
    end else begin
      if (qv > (SAMPLE_W+1)'({1'b1, {(SAMPLE_W-1){1'b0}}}))
        res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      else
        res = ~qv[SAMPLE_W-1:0] + 1'b1;
    end
    return res;
  endfunction

  logic      out_v_r;
  out_item_t out_item_r;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= div_v_r[DIV_STEPS];
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      out_v_r <= s5_v_r;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r   <= t_div;
      s1_lg_r  <= lg_nxt;
      s1_ctx_r <= div_ctx_r[DIV_STEPS];
      s2_t_r   <= s1_t_r;
      s2_q_r   <= q_prod[38:15];
      s2_ctx_r <= s1_ctx_r;
      s3_r_r   <= r_nxt;
      s3_ctx_r <= s2_ctx_r;
      s4_g_r   <= g_nxt;
      s4_ctx_r <= s3_ctx_r;
      s5_eff_r <= eff_nxt;
      s5_ctx_r <= s4_ctx_r;
      out_item_r.out_left       <= scale_sample(s5_ctx_r.left, s5_eff_r);
      out_item_r.out_right      <= scale_sample(s5_ctx_r.right, s5_eff_r);
      out_item_r.effective_gain <= s5_eff_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

### hw/rtl/tgs_checker.sv
// Port-level checks for the tempo-synced gain shaper, bound to the top level.
// Depends on tgs_pkg and tempo_synced_gain_shaper.
module tgs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tgs_pkg::out_item_t out_item,
  input logic               cfg_ready
);
  import tgs_pkg::*;

  // Reset empties the result side
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  // Zero gain silences both channels
  a_zero_gain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.effective_gain == '0 |->
      out_item.out_left == '0 && out_item.out_right == '0)
    else $error("nonzero sample with zero gain");

  // Register writes are never refused
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind tempo_synced_gain_shaper tgs_checker u_tgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_ready (cfg_ready)
);

### sim/tempo_synced_gain_shaper_tb.sv
// Testbench for the tempo-synced gain shaper: random and directed frames checked
// against a scoreboard that predicts gain and scaled samples per frame.
// Depends on tgs_pkg and the tempo_synced_gain_shaper top level.
module tempo_synced_gain_shaper_tb;
  import tgs_pkg::*;

  localparam int NPTS       = 5;
  localparam int TAB_SIZE   = 256;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 40;

  // Scoreboard: own copy of the registers, tables and the queue of pending results
  class gain_board;
    logic [31:0] step_q32;
    logic [15:0] mix_q15;
    logic [2:0]  npoints;
    logic [48:0] pts [NPTS];
    logic [15:0] log_lut [TAB_SIZE];
    logic [31:0] exp_lut [TAB_SIZE];
    out_item_t   pending [$];
    int          mismatches;

    function new();
      logic [63:0] roots [17];
      logic [63:0] x, fr, acc;
      logic [15:0] y;
      step_q32   = 32'd194783;
      mix_q15    = 16'd32768;
      npoints    = 3'd3;
      mismatches = 0;
      foreach (pts[i]) pts[i] = '0;
      pts[1] = 49'd140741783339008;
      pts[2] = 49'd4295032832;
      roots[0] = 64'd1 << 29;
      for (int i = 1; i <= 16; i++) roots[i] = root64(roots[i-1] << 30);
      for (int k = 0; k < TAB_SIZE; k++) begin
        x   = (64'd1 << 30) + ((64'(k) << 30) / TAB_SIZE);
        fr  = (64'(k) << 16) / TAB_SIZE;
        y   = '0;
        acc = 64'd1 << 30;
        for (int i = 1; i <= 16; i++) begin
          x = (x * x) >> 30;
          if (x >= (64'd2 << 30)) begin
            x = x >> 1;
            y[16-i] = 1'b1;
          end
          if (fr[16-i]) acc = (acc * roots[i]) >> 30;
        end
        log_lut[k] = y;
        exp_lut[k] = 32'(acc >> 14);
      end
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bv;
      res = '0;
      bv  = 64'd1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
        if (v >= res + bv) begin
          v   = v - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
      return res;
    endfunction

    function void write_reg(logic [2:0] idx, logic [48:0] data);
      if (idx == REG_PHASE_STEP) step_q32 = data[31:0];
      else if (idx == REG_MIX_AMOUNT) mix_q15 = data[15:0];
      else if (idx == REG_POINT_CNT) npoints = data[2:0];
      else if (int'(idx) >= REG_POINT_BASE && int'(idx) < REG_POINT_BASE + NPTS)
        pts[int'(idx) - REG_POINT_BASE] = data;
    endfunction

    // t^e with t in Q0.16 and e in Q.15, through the log and exp tables
    function logic [31:0] shape_pow(logic [31:0] t, logic [31:0] e);
      int          n;
      logic [31:0] m, idx, ip, fp;
      logic [63:0] lg, q;
      if (t == 0) return 0;
      n = 15;
      while (n > 0 && t[n] == 1'b0) n--;
      m   = t << (15 - n);
      idx = 32'((64'(m - 32'd32768) * TAB_SIZE) >> 15);
      lg  = (64'(16 - n) << 16) - 64'(log_lut[idx]);
      q   = (lg * 64'(e)) >> 15;
      ip  = 32'(q >> 16);
      fp  = 32'(q & 64'hFFFF);
      if (ip >= 32) return 0;
      return exp_lut[(64'(fp) * TAB_SIZE) >> 16] >> ip;
    endfunction

    function logic [31:0] curve_lookup(logic [31:0] p);
      int                 cnt;
      logic [31:0]        x0, x1, y0, y1, t, r;
      logic signed [31:0] c;
      cnt = (npoints > NPTS) ? NPTS : int'(npoints);
      if (cnt == 0) return 32'd32768;
      if (p <= pts[0][16:0]) return pts[0][32:17];
      if (p >= pts[cnt-1][16:0]) return pts[cnt-1][32:17];
      for (int i = 0; i + 1 < cnt; i++) begin
        x0 = pts[i][16:0];
        x1 = pts[i+1][16:0];
        if (p >= x0 && p < x1) begin
          t  = 32'((64'(p - x0) << 16) / 64'(x1 - x0));
          c  = 32'(signed'(pts[i][48:33]));
          y0 = pts[i][32:17];
          y1 = pts[i+1][32:17];
          if (c > 0) r = shape_pow(t, 32'd32768 - ((32'(c) * 32'd29491) >> 15));
          else if (c < 0) r = shape_pow(t, 32'd32768 + 32'd4 * 32'(-c));
          else r = t;
          if (y1 >= y0) return y0 + 32'((64'(r) * 64'(y1 - y0)) >> 16);
          return y0 - 32'((64'(r) * 64'(y0 - y1)) >> 16);
        end
      end
      return 32'd32768;
    endfunction

    function logic signed [23:0] scale_sample(logic [23:0] raw, logic [31:0] eff);
      logic [63:0]        mag;
      logic signed [63:0] r;
      mag = raw[23] ? ((64'd1 << 24) - 64'(raw)) : 64'(raw);
      r   = signed'((mag * 64'(eff)) >> 15);
      if (raw[23]) r = -r;
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return r[23:0];
    endfunction

    // Predict the result of one accepted frame
    function void note_frame(in_item_t item);
      logic [63:0]        prod;
      logic [31:0]        g, eff;
      logic signed [63:0] v;
      out_item_t          exp_item;
      eff = 32'd32768;
      if (mix_q15 >= 16'd33 && npoints != 0) begin
        prod = 64'(item.frame_number[31:0]) * 64'(step_q32);
        g    = curve_lookup(32'(prod[31:16]));
        if (g >= 32'd32768)
          v = 64'sd32768 + signed'((64'(g - 32'd32768) * 64'(mix_q15)) >> 15);
        else
          v = 64'sd32768 - signed'((64'(32'd32768 - g) * 64'(mix_q15)) >> 15);
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        eff = 32'(v);
      end
      exp_item.out_left       = scale_sample(item.in_left, eff);
      exp_item.out_right      = scale_sample(item.in_right, eff);
      exp_item.effective_gain = eff[15:0];
      pending.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
          got.effective_gain !== want.effective_gain) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected L=%0d R=%0d G=%0d, got L=%0d R=%0d G=%0d",
                   want.out_left, want.out_right, want.effective_gain,
                   got.out_left, got.out_right, got.effective_gain);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [48:0] cfg_data = '0;

  gain_board board = new();
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  no_stall = 1'b0;
  logic [47:0] next_frame = '0;

  tempo_synced_gain_shaper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Observe every beat on all three channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) board.note_frame(in_item);
      if (out_valid && out_ready) board.check_result(out_item);
    end
  end

  // Result-side backpressure: random stall after each beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) stall_left = no_stall ? 0 : $urandom_range(0, 6);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [48:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Send one frame after a random gap; valid drops only when a gap follows
  task automatic send_frame(logic [47:0] fn, logic [23:0] l, logic [23:0] r);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item.frame_number <= fn;
    in_item.in_left      <= l;
    in_item.in_right     <= r;
    in_valid             <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold until all results are back, then let the pipe settle
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [48:0] pack_point(logic [16:0] x, logic [15:0] y,
                                             logic [15:0] c);
    return {c, y, x};
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_curve();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Load a random curve; sorted unless asked otherwise
  task automatic load_curve(bit sorted, bit wide_y);
    logic [16:0] xs [NPTS];
    logic [16:0] tmp;
    logic [15:0] y;
    foreach (xs[i]) xs[i] = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65535));
    if (sorted) begin
      for (int i = 0; i < NPTS; i++)
        for (int j = 0; j + 1 < NPTS - i; j++)
          if (xs[j] > xs[j+1]) begin
            tmp = xs[j]; xs[j] = xs[j+1]; xs[j+1] = tmp;
          end
    end
    for (int i = 0; i < NPTS; i++) begin
      y = wide_y ? 16'($urandom) : 16'($urandom_range(0, 32768));
      cfg_write(3'(REG_POINT_BASE + i), pack_point(xs[i], y, rand_curve()));
    end
  endtask

  initial begin
    int plen;
    logic [31:0] steps [6];
    logic [15:0] mixes [6];
    steps = '{32'd1, 32'hFFFFFFFF, 32'd65536, 32'd0, 32'd194783, 32'h0123_4567};
    mixes = '{16'd0, 16'd32, 16'd33, 16'd32768, 16'hFFFF, 16'd16384};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset curve with extreme frames and samples
    send_frame(48'd0, 24'h7FFFFF, 24'h800000);
    send_frame(48'hFFFF_FFFF_FFFF, 24'h800000, 24'h7FFFFF);
    send_frame(48'd12345, 24'hFFFFFF, 24'h000001);
    send_frame(48'hAAAA_5555_AAAA, 24'h555555, 24'hAAAAAA);
    drain();

    // Phase equals frame bits 15:0; hit segment edges and every curve sign
    cfg_write(REG_PHASE_STEP, 49'd65536);
    cfg_write(REG_POINT_CNT, 49'd5);
    cfg_write(3'(REG_POINT_BASE + 0), pack_point(17'd0, 16'd0, 16'h8000));
    cfg_write(3'(REG_POINT_BASE + 1), pack_point(17'd16384, 16'hFFFF, 16'h7FFF));
    cfg_write(3'(REG_POINT_BASE + 2), pack_point(17'd32768, 16'd8000, 16'h0000));
    cfg_write(3'(REG_POINT_BASE + 3), pack_point(17'd49152, 16'd40000, 16'hFF9C));
    cfg_write(3'(REG_POINT_BASE + 4), pack_point(17'd65535, 16'd32768, 16'h0000));
    foreach (mixes[i]) if (i == 3) ;
    send_frame(48'd0, 24'h7FFFFF, 24'h800000);
    send_frame(48'd1, 24'h7FFFFF, 24'h800000);
    send_frame(48'd8192, 24'h400000, 24'hC00000);
    send_frame(48'd16384, 24'h7FFFFF, 24'h800000);
    send_frame(48'd16385, 24'h7FFFFF, 24'h800000);
    send_frame(48'd24576, 24'h123456, 24'hEDCBA9);
    send_frame(48'd32768, 24'h7FFFFF, 24'h800000);
    send_frame(48'd40000, 24'h7FFFFF, 24'h800000);
    send_frame(48'd50000, 24'h7FFFFF, 24'h800000);
    send_frame(48'd65535, 24'h7FFFFF, 24'h800000);
    drain();
    // More points requested than exist
    cfg_write(REG_POINT_CNT, 49'd7);
    send_frame(48'd20000, 24'h7FFFFF, 24'h800000);
    send_frame(48'd60000, 24'h7FFFFF, 24'h800000);
    drain();

    // Random phases, each with its own setting
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_PHASE_STEP, (ph < 6) ? 49'(steps[ph]) : 49'($urandom));
      cfg_write(REG_MIX_AMOUNT, (ph < 6) ? 49'(mixes[ph]) : 49'($urandom_range(33, 32768)));
      cfg_write(REG_POINT_CNT, (ph == 1) ? 49'd0 : 49'($urandom_range(1, 7)));
      load_curve(ph != 5, ph == 4);
      no_stall   = (ph == 6);
      next_frame = {16'($urandom), 32'($urandom)};
      plen = 105;
      for (int k = 0; k < plen; k++) begin
        // Mostly a running frame counter, sometimes a jump
        if ($urandom_range(0, 9) < 8) next_frame = next_frame + 48'd1;
        else next_frame = {16'($urandom), 32'($urandom)};
        send_frame(next_frame, rand_sample(), rand_sample());
        if (ph == 2 && k == 50) begin
          in_valid <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
